// ===== rtl/ecb_pmu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the event counter bank PMU.
// No dependencies; imported by every module of the block.

package ecb_pmu_pkg;

  // Request command codes as they arrive on the input channel
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register map
  typedef enum logic [3:0] {
    REG_CONTROL  = 4'd0,
    REG_ENSET    = 4'd1,
    REG_ENCLR    = 4'd2,
    REG_INTSET   = 4'd3,
    REG_INTCLR   = 4'd4,
    REG_OVERFLOW = 4'd5,
    REG_SELECT   = 4'd6,
    REG_EVTYPE   = 4'd7,
    REG_EVCOUNT  = 4'd8,
    REG_CYCLES   = 4'd9
  } reg_t;

  // Classified operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_TICK  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_BAD   = 3'd4
  } op_kind_t;

  // data carries write_data on register accesses, the event vector on ticks
  typedef struct packed {
    op_kind_t    kind;
    reg_t        addr;
    logic [31:0] data;
  } op_t;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned CYCLE_BIT    = 31;
  localparam int unsigned PMCR_N_SHIFT = 11;
  localparam int unsigned EVENT_W      = 30;
  localparam logic [7:0]  MAX_EVENT    = 8'h1D;

endpackage

// ===== rtl/ecb_pmu_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests and classifies them into operations.
// Depends on ecb_pmu_pkg.

module ecb_pmu_front
  import ecb_pmu_pkg::*;
(
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [3:0]           reg_addr,
  input  logic [31:0]          write_data,
  input  logic [EVENT_W-1:0]   event_vector,
  input  logic                 queue_full,
  output logic                 push,
  output op_t                  push_op
);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_op.kind = OP_NOP;
    push_op.addr = REG_CONTROL;
    push_op.data = write_data;
    unique case (cmd_t'(command)) inside
      CMD_WRITE, CMD_READ: begin
        if (reg_addr <= REG_CYCLES) begin
          push_op.kind = (cmd_t'(command) == CMD_WRITE) ? OP_WRITE : OP_READ;
          push_op.addr = reg_t'(reg_addr);
        end else begin
          push_op.kind = OP_BAD;
        end
      end
      CMD_TICK: begin
        push_op.kind = OP_TICK;
        push_op.data = {{(32 - EVENT_W){1'b0}}, event_vector};
      end
      default: begin
        push_op.kind = OP_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/ecb_pmu_queue.sv =====
`timescale 1ns / 1ps
// Short operation queue between the front and back ends.
// Depends on ecb_pmu_pkg (op_t, QUEUE_DEPTH).

module ecb_pmu_queue
  import ecb_pmu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic not_empty,
  output logic full
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  op_t             entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head_op   = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CntW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CntW'(1))
    else $error("push did not grow queue");

endmodule

// ===== rtl/ecb_pmu_back.sv =====
`timescale 1ns / 1ps
// Back end: PMU register state, counter updates and the result register.
// Depends on ecb_pmu_pkg.

module ecb_pmu_back
  import ecb_pmu_pkg::*;
#(
  parameter int NUM_COUNTERS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  input  op_t         op,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq,
  output logic        access_error
);

  localparam int          IdxW      = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam logic [5:0]  SelLimit  = 6'(NUM_COUNTERS);
  localparam logic [31:0] CtrlNBits = 32'(NUM_COUNTERS % 32) << PMCR_N_SHIFT;

  logic                    unit_enable, unit_enable_next;
  logic [NUM_COUNTERS-1:0] cnt_en, cnt_en_next;
  logic                    cyc_en, cyc_en_next;
  logic [NUM_COUNTERS-1:0] irq_en, irq_en_next;
  logic                    irq_cyc_en, irq_cyc_en_next;
  logic [NUM_COUNTERS-1:0] ovf, ovf_next;
  logic                    ovf_cyc, ovf_cyc_next;
  logic [4:0]              selected_counter, selected_counter_next;
  logic [7:0]              event_types [NUM_COUNTERS];
  logic [7:0]              event_types_next [NUM_COUNTERS];
  logic [31:0]             event_counts [NUM_COUNTERS];
  logic [31:0]             event_counts_next [NUM_COUNTERS];
  logic [31:0]             cycle_count, cycle_count_next;

  logic            sel_ok;
  logic [IdxW-1:0] sel_idx;
  logic [31:0]     rd;
  logic            err;
  logic            irq_next;

  assign pop     = op_valid && (!out_valid || !out_stall);
  assign sel_ok  = {1'b0, selected_counter} < SelLimit;
  assign sel_idx = selected_counter[IdxW-1:0];

  always_comb begin
    unit_enable_next      = unit_enable;
    cnt_en_next           = cnt_en;
    cyc_en_next           = cyc_en;
    irq_en_next           = irq_en;
    irq_cyc_en_next       = irq_cyc_en;
    ovf_next              = ovf;
    ovf_cyc_next          = ovf_cyc;
    selected_counter_next = selected_counter;
    event_types_next      = event_types;
    event_counts_next     = event_counts;
    cycle_count_next      = cycle_count;
    rd                    = '0;
    err                   = 1'b0;

    if (pop) begin
      unique case (op.kind)
        OP_TICK: begin
          if (unit_enable) begin
            if (cyc_en) begin
              cycle_count_next = cycle_count + 32'd1;
              if (cycle_count == '1) begin
                ovf_cyc_next = 1'b1;
              end
            end
            for (int i = 0; i < NUM_COUNTERS; i++) begin
              if (cnt_en[i] && event_types[i] <= MAX_EVENT &&
                  op.data[event_types[i][4:0]]) begin
                event_counts_next[i] = event_counts[i] + 32'd1;
                if (event_counts[i] == '1) begin
                  ovf_next[i] = 1'b1;
                end
              end
            end
          end
        end
        OP_WRITE: begin
          unique case (op.addr)
            REG_CONTROL: begin
              unit_enable_next = op.data[0];
              if (op.data[1]) begin
                for (int i = 0; i < NUM_COUNTERS; i++) begin
                  event_counts_next[i] = '0;
                end
              end
              if (op.data[2]) begin
                cycle_count_next = '0;
              end
            end
            REG_ENSET: begin
              cnt_en_next = cnt_en | op.data[NUM_COUNTERS-1:0];
              cyc_en_next = cyc_en | op.data[CYCLE_BIT];
            end
            REG_ENCLR: begin
              cnt_en_next = cnt_en & ~op.data[NUM_COUNTERS-1:0];
              cyc_en_next = cyc_en & ~op.data[CYCLE_BIT];
            end
            REG_INTSET: begin
              irq_en_next     = irq_en | op.data[NUM_COUNTERS-1:0];
              irq_cyc_en_next = irq_cyc_en | op.data[CYCLE_BIT];
            end
            REG_INTCLR: begin
              irq_en_next     = irq_en & ~op.data[NUM_COUNTERS-1:0];
              irq_cyc_en_next = irq_cyc_en & ~op.data[CYCLE_BIT];
            end
            REG_OVERFLOW: begin
              ovf_next     = ovf & ~op.data[NUM_COUNTERS-1:0];
              ovf_cyc_next = ovf_cyc & ~op.data[CYCLE_BIT];
            end
            REG_SELECT: begin
              selected_counter_next = op.data[4:0];
            end
            REG_EVTYPE: begin
              if (sel_ok) event_types_next[sel_idx] = op.data[7:0];
              else        err = 1'b1;
            end
            REG_EVCOUNT: begin
              if (sel_ok) event_counts_next[sel_idx] = op.data;
              else        err = 1'b1;
            end
            REG_CYCLES: begin
              cycle_count_next = op.data;
            end
            default: begin
              err = 1'b1;
            end
          endcase
        end
        OP_READ: begin
          unique case (op.addr) inside
            REG_CONTROL: begin
              rd    = CtrlNBits;
              rd[0] = unit_enable;
            end
            REG_ENSET, REG_ENCLR: begin
              rd            = 32'(cnt_en);
              rd[CYCLE_BIT] = cyc_en;
            end
            REG_INTSET, REG_INTCLR: begin
              rd            = 32'(irq_en);
              rd[CYCLE_BIT] = irq_cyc_en;
            end
            REG_OVERFLOW: begin
              rd            = 32'(ovf);
              rd[CYCLE_BIT] = ovf_cyc;
            end
            REG_SELECT: begin
              rd = 32'(selected_counter);
            end
            REG_EVTYPE: begin
              if (sel_ok) rd = 32'(event_types[sel_idx]);
              else        err = 1'b1;
            end
            REG_EVCOUNT: begin
              if (sel_ok) rd = event_counts[sel_idx];
              else        err = 1'b1;
            end
            REG_CYCLES: begin
              rd = cycle_count;
            end
            default: begin
              err = 1'b1;
            end
          endcase
        end
        OP_BAD: begin
          err = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign irq_next = (|(ovf_next & irq_en_next)) | (ovf_cyc_next & irq_cyc_en_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_enable      <= 1'b0;
      cnt_en           <= '0;
      cyc_en           <= 1'b0;
      irq_en           <= '0;
      irq_cyc_en       <= 1'b0;
      ovf              <= '0;
      ovf_cyc          <= 1'b0;
      selected_counter <= '0;
      cycle_count      <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        event_types[i]  <= '0;
        event_counts[i] <= '0;
      end
    end else begin
      unit_enable      <= unit_enable_next;
      cnt_en           <= cnt_en_next;
      cyc_en           <= cyc_en_next;
      irq_en           <= irq_en_next;
      irq_cyc_en       <= irq_cyc_en_next;
      ovf              <= ovf_next;
      ovf_cyc          <= ovf_cyc_next;
      selected_counter <= selected_counter_next;
      cycle_count      <= cycle_count_next;
      event_types      <= event_types_next;
      event_counts     <= event_counts_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      read_data    <= rd;
      irq          <= irq_next;
      access_error <= err;
    end
  end

  a_err_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_error |-> read_data == '0)
    else $error("errored access returned nonzero data");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("executed operation produced no result");

  a_disabled_tick_holds: assert property (@(posedge clk) disable iff (rst)
    pop && op.kind == OP_TICK && !unit_enable |=> $stable(cycle_count))
    else $error("cycle counter moved while unit disabled");

endmodule

// ===== rtl/event_counter_bank_pmu.sv =====
`timescale 1ns / 1ps
// Performance monitor unit: event counter bank plus cycle counter.
// Depends on ecb_pmu_pkg, ecb_pmu_front, ecb_pmu_queue, ecb_pmu_back.

// Each request is a register write, a register read or an event tick, and
// each gives exactly one result (read_data, irq, access_error) in request
// order. While the output is not stalled the block sustains one request per
// clock: the front end classifies a request combinationally into a two-entry
// queue, and the back end takes one operation per cycle from the queue,
// updates all counters in parallel and loads the result register. An
// accepted request is written into the queue, and the result register loads
// when the back end pops it. A stalled output fills the queue, and in_stall
// rises only once both queue entries are held. Masks use bit i for event
// counter i and bit 31 for the cycle counter; irq reflects state after the
// request that produced it. Unknown addresses and evtype/evcount access
// with the selector beyond the bank flag access_error and change nothing.

module event_counter_bank_pmu
  import ecb_pmu_pkg::*;
#(
  parameter int NUM_COUNTERS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [3:0]         reg_addr,
  input  logic [31:0]        write_data,
  input  logic [EVENT_W-1:0] event_vector,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        read_data,
  output logic               irq,
  output logic               access_error
);

  logic push;
  op_t  push_op;
  logic pop;
  op_t  head_op;
  logic not_empty;
  logic full;

  ecb_pmu_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .reg_addr     (reg_addr),
    .write_data   (write_data),
    .event_vector (event_vector),
    .queue_full   (full),
    .push         (push),
    .push_op      (push_op)
  );

  ecb_pmu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .head_op   (head_op),
    .not_empty (not_empty),
    .full      (full)
  );

  ecb_pmu_back #(
    .NUM_COUNTERS (NUM_COUNTERS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (not_empty),
    .op           (head_op),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .irq          (irq),
    .access_error (access_error)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for event_counter_bank_pmu: directed register and
// counting tests, then random request traffic under varying flow control.
// Depends on ecb_pmu_pkg and the event_counter_bank_pmu RTL.

module testbench;
  import ecb_pmu_pkg::*;

  localparam int N_CTR = 4;
  // Control register bits
  localparam int CTRL_E = 0;
  localparam int CTRL_P = 1;
  localparam int CTRL_C = 2;
  // Addresses with no register behind them
  localparam logic [3:0] ADDR_UNMAPPED_LO = 4'd10;
  localparam logic [3:0] ADDR_UNMAPPED_HI = 4'd15;
  // Mask bits that exist: one per event counter plus the cycle counter
  localparam logic [31:0] LIVE_BITS = ((32'd1 << N_CTR) - 32'd1) | (32'd1 << CYCLE_BIT);
  localparam int RANDOM_PER_PHASE = 262;
  localparam int SETTLE_CYCLES = 10;
  localparam int TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
    logic        err;
  } pmu_response_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = CMD_NONE;
  logic [3:0]         reg_addr = '0;
  logic [31:0]        write_data = '0;
  logic [EVENT_W-1:0] event_vector = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        read_data;
  logic               irq;
  logic               access_error;

  // Flow-control knobs, in percent
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor copy of the PMU state
  logic              pmu_on = 1'b0;
  logic [31:0]       cnt_en = '0;
  logic [31:0]       int_en = '0;
  logic [31:0]       ovf = '0;
  logic [4:0]        sel = '0;
  logic [7:0]        ev_type [N_CTR] = '{default: '0};
  logic [31:0]       ev_cnt [N_CTR] = '{default: '0};
  logic [31:0]       cyc = '0;

  pmu_response_t expected_responses[$];
  int fail_count = 0;
  int n_requests = 0, n_ticks = 0, n_reads = 0, n_writes = 0, n_unused = 0;
  int n_wraps = 0, n_errors = 0, n_irq = 0;

  event_counter_bank_pmu #(
    .NUM_COUNTERS(N_CTR)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .reg_addr(reg_addr),
    .write_data(write_data),
    .event_vector(event_vector),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .irq(irq),
    .access_error(access_error)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Applies one accepted request to the predictor state and returns the
  // response it should produce. irq is taken after the update.
  function automatic pmu_response_t predict_response(logic [1:0] cmd, logic [3:0] addr,
                                                     logic [31:0] data,
                                                     logic [EVENT_W-1:0] ev);
    pmu_response_t res;
    logic sel_ok;
    int i;
    res = '0;
    sel_ok = (sel < N_CTR);
    n_requests++;
    case (cmd)
      CMD_TICK: begin
        n_ticks++;
        if (pmu_on) begin
          if (cnt_en[CYCLE_BIT]) begin
            cyc = cyc + 32'd1;
            if (cyc == 32'd0) begin
              ovf[CYCLE_BIT] = 1'b1;
              n_wraps++;
            end
          end
          for (i = 0; i < N_CTR; i++) begin
            // types above the last event code never count
            if (cnt_en[i] && ev_type[i] <= MAX_EVENT && ev[ev_type[i]]) begin
              ev_cnt[i] = ev_cnt[i] + 32'd1;
              if (ev_cnt[i] == 32'd0) begin
                ovf[i] = 1'b1;
                n_wraps++;
              end
            end
          end
        end
      end
      CMD_WRITE: begin
        n_writes++;
        case (addr)
          REG_CONTROL: begin
            pmu_on = data[CTRL_E];
            if (data[CTRL_P]) begin
              for (i = 0; i < N_CTR; i++) ev_cnt[i] = '0;
            end
            if (data[CTRL_C]) cyc = '0;
          end
          REG_ENSET:    cnt_en = cnt_en | (data & LIVE_BITS);
          REG_ENCLR:    cnt_en = cnt_en & ~(data & LIVE_BITS);
          REG_INTSET:   int_en = int_en | (data & LIVE_BITS);
          REG_INTCLR:   int_en = int_en & ~(data & LIVE_BITS);
          REG_OVERFLOW: ovf = ovf & ~(data & LIVE_BITS);
          REG_SELECT:   sel = data[4:0];
          REG_EVTYPE: begin
            if (sel_ok) ev_type[sel] = data[7:0];
            else res.err = 1'b1;
          end
          REG_EVCOUNT: begin
            if (sel_ok) ev_cnt[sel] = data;
            else res.err = 1'b1;
          end
          REG_CYCLES:   cyc = data;
          default:      res.err = 1'b1;
        endcase
      end
      CMD_READ: begin
        n_reads++;
        case (addr)
          REG_CONTROL: res.rd = (32'(N_CTR & 31) << PMCR_N_SHIFT) | 32'(pmu_on);
          REG_ENSET, REG_ENCLR:   res.rd = cnt_en;
          REG_INTSET, REG_INTCLR: res.rd = int_en;
          REG_OVERFLOW: res.rd = ovf;
          REG_SELECT:   res.rd = 32'(sel);
          REG_EVTYPE: begin
            if (sel_ok) res.rd = 32'(ev_type[sel]);
            else res.err = 1'b1;
          end
          REG_EVCOUNT: begin
            if (sel_ok) res.rd = ev_cnt[sel];
            else res.err = 1'b1;
          end
          REG_CYCLES:   res.rd = cyc;
          default:      res.err = 1'b1;
        endcase
      end
      default: n_unused++;
    endcase
    res.irq = |(ovf & int_en & LIVE_BITS);
    if (res.err) n_errors++;
    if (res.irq) n_irq++;
    return res;
  endfunction

  // Every request accepted at this edge gets its expected response queued
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_responses.push_back(predict_response(command, reg_addr, write_data,
                                                    event_vector));
    end
  end

  // Response checker: in-order compare against the oldest expectation
  always @(posedge clk) begin
    pmu_response_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        $error("response with nothing expected: read_data=%h irq=%b access_error=%b",
               read_data, irq, access_error);
        fail_count++;
      end else begin
        want = expected_responses.pop_front();
        if (read_data !== want.rd) begin
          $error("read_data: expected %h, got %h", want.rd, read_data);
          fail_count++;
        end
        if (irq !== want.irq) begin
          $error("irq: expected %b, got %b", want.irq, irq);
          fail_count++;
        end
        if (access_error !== want.err) begin
          $error("access_error: expected %b, got %b", want.err, access_error);
          fail_count++;
        end
      end
    end
  end

  // Sends one request; valid stays high on return so back-to-back requests
  // never drop it. Called and returns at a rising edge.
  task automatic send_request(cmd_t cmd, logic [3:0] addr, logic [31:0] data,
                              logic [EVENT_W-1:0] ev);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    reg_addr     <= addr;
    write_data   <= data;
    event_vector <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    send_request(CMD_WRITE, addr, data, EVENT_W'($urandom));
  endtask

  task automatic reg_read(logic [3:0] addr);
    send_request(CMD_READ, addr, $urandom, EVENT_W'($urandom));
  endtask

  task automatic tick(logic [EVENT_W-1:0] ev);
    send_request(CMD_TICK, 4'($urandom), $urandom, ev);
  endtask

  // Sender holds off until every outstanding response is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  // Reset values, unmapped addresses, the unused command
  task automatic test_reset_state();
    reg_read(REG_CONTROL);
    reg_read(REG_EVCOUNT);
    reg_read(REG_CYCLES);
    reg_read(ADDR_UNMAPPED_HI);
    reg_write(ADDR_UNMAPPED_LO, 32'hFFFF_FFFF);
    send_request(CMD_NONE, ADDR_UNMAPPED_HI, 32'hFFFF_FFFF, '1);
  endtask

  // Set/clear masks with bits that name no counter, selector extremes,
  // evtype/evcount access with the selector past the bank
  task automatic test_register_map();
    reg_write(REG_ENSET, 32'hFFFF_FFFF);
    reg_write(REG_ENCLR, 32'h7FFF_FFF0);
    reg_read(REG_ENCLR);
    reg_write(REG_INTSET, 32'hFFFF_FFFF);
    reg_write(REG_INTCLR, 32'hFFFF_FFFF);
    reg_read(REG_INTSET);
    reg_write(REG_SELECT, 32'hFFFF_FFFF);
    reg_read(REG_EVTYPE);
    reg_write(REG_EVCOUNT, 32'h1234_5678);
    reg_write(REG_SELECT, 32'h0);
    reg_write(REG_EVTYPE, 32'hFFFF_FFFF);
    reg_read(REG_EVTYPE);
  endtask

  // Unknown event type, wrap of an event counter and the cycle counter,
  // overflow clear, counter reset bits, ticks while the unit is off
  task automatic test_counting_and_overflow();
    reg_write(REG_INTSET, 32'hFFFF_FFFF);
    reg_write(REG_CONTROL, 32'h1 << CTRL_E);
    tick('1);
    reg_write(REG_EVTYPE, 32'(MAX_EVENT));
    reg_write(REG_EVCOUNT, 32'hFFFF_FFFF);
    reg_write(REG_CYCLES, 32'hFFFF_FFFF);
    tick('1);
    reg_read(REG_OVERFLOW);
    reg_write(REG_OVERFLOW, 32'hFFFF_FFFF);
    reg_write(REG_CONTROL, (32'h1 << CTRL_E) | (32'h1 << CTRL_P) | (32'h1 << CTRL_C));
    reg_write(REG_CONTROL, 32'h0);
    tick('1);
    reg_read(REG_CYCLES);
  endtask

  // One random request, biased so counters stay enabled and often sit near
  // their wrap point
  task automatic random_request();
    int unsigned pick;
    logic [3:0] addr;
    logic [31:0] data;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) addr = 4'($urandom_range(ADDR_UNMAPPED_HI, ADDR_UNMAPPED_LO));
    else addr = 4'($urandom_range(REG_CYCLES));
    data = $urandom;
    if (pick < 45) begin
      send_request(CMD_TICK, addr, data, EVENT_W'($urandom));
    end else if (pick < 80) begin
      case (addr)
        REG_CONTROL: begin
          data[CTRL_E] = ($urandom_range(9) != 0);
          if ($urandom_range(15) != 0) begin
            data[CTRL_P] = 1'b0;
            data[CTRL_C] = 1'b0;
          end
        end
        REG_ENCLR, REG_INTCLR: data = data & $urandom;
        REG_SELECT: if ($urandom_range(7) != 0) data[4:0] = 5'($urandom_range(N_CTR - 1));
        REG_EVTYPE: if ($urandom_range(7) != 0) data[7:0] = 8'($urandom_range(MAX_EVENT));
        REG_EVCOUNT, REG_CYCLES: if ($urandom_range(1)) data = 32'hFFFF_FFFF - $urandom_range(40);
        default: ;
      endcase
      send_request(CMD_WRITE, addr, data, EVENT_W'($urandom));
    end else if (pick < 97) begin
      send_request(CMD_READ, addr, data, EVENT_W'($urandom));
    end else begin
      send_request(CMD_NONE, addr, data, EVENT_W'($urandom));
    end
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct, int count);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) random_request();
    wait_for_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_map();
    test_counting_and_overflow();

    test_random_traffic(0, 0, RANDOM_PER_PHASE);
    test_random_traffic(61, 0, RANDOM_PER_PHASE);
    test_random_traffic(0, 61, RANDOM_PER_PHASE);
    test_random_traffic(38, 38, RANDOM_PER_PHASE);

    recv_stall_pct = 0;
    wait_for_drain();
    // Nothing more should come out after the last expected response
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d expected responses never arrived", expected_responses.size());
      fail_count++;
    end

    $display("Ran %0d requests: %0d ticks, %0d reads, %0d writes, %0d unused commands",
             n_requests, n_ticks, n_reads, n_writes, n_unused);
    $display("Saw %0d counter wraps, %0d access errors, %0d responses with irq high",
             n_wraps, n_errors, n_irq);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #TIMEOUT_NS;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ecb_pmu_pkg.sv
rtl/ecb_pmu_front.sv
rtl/ecb_pmu_queue.sv
rtl/ecb_pmu_back.sv
rtl/event_counter_bank_pmu.sv
tb/testbench.sv
